@@ sv/dns_message_parser_assert.svh @@
// ---------------------------------------------------------------------------
// DNS message parser assertion macros
// Clocked assertion wrappers; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef DNS_MESSAGE_PARSER_ASSERT_SVH
`define DNS_MESSAGE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define DMP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dns_message_parser assertion failed");

// Check a property on every clock edge, reset included.
`define DMP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dns_message_parser assertion failed");

`else

`define DMP_ASSERT(lbl, prop)
`define DMP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ sv/dmp_pkg.sv @@
// ---------------------------------------------------------------------------
// DNS message parser package
// Phase and result-kind codes, header offsets and the result record.
// ---------------------------------------------------------------------------
package dmp_pkg;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_HEADER     = 4'd1,
        PH_LABEL_LEN  = 4'd2,
        PH_LABEL_CHAR = 4'd3,
        PH_TAIL       = 4'd4,
        PH_RDATA      = 4'd5,
        PH_DONE       = 4'd6
    } phase_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_CHAR     = 3'd0,
        KIND_NAME_END = 3'd1,
        KIND_QTYPE    = 3'd2,
        KIND_ANSWER   = 3'd3,
        KIND_ADDR     = 3'd4
    } kind_t;

    // Record type AAAA
    localparam logic [15:0] AAAA_TYPE = 16'd28;

    // Offsets within the length prefix and header
    localparam logic [3:0] ANCOUNT_HI_AT  = 4'd8;
    localparam logic [3:0] ANCOUNT_LO_AT  = 4'd9;
    localparam logic [3:0] HEADER_LAST_AT = 4'd13;

    // Offsets within the bytes after the question name
    localparam logic [3:0] QTYPE_LO_AT = 4'd1;
    localparam logic [3:0] ATYPE_LO_AT = 4'd7;
    localparam logic [3:0] RDLEN_LO_AT = 4'd15;

    // One result record
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] value;
        logic       label_end;
        logic       verdict;
        logic       last_byte;
    } res_t;

endpackage

@@ sv/dmp_walker.sv @@
// ---------------------------------------------------------------------------
// DNS message walker
// Parser state and the single-pass step for one message byte.
// ---------------------------------------------------------------------------
`include "dns_message_parser_assert.svh"

module dmp_walker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     data_byte,
    input  logic           first,
    output dmp_pkg::res_t  res
);

    dmp_pkg::phase_t phase_reg, phase_next, ph_e;
    logic [3:0]      offset_reg, offset_next, off_e;
    logic [7:0]      label_left_reg, label_left_next, label_e;
    logic            answers_reg, answers_next, ans_e;
    logic [7:0]      hold_reg, hold_next, hold_e;
    logic [15:0]     rdata_left_reg, rdata_left_next, rdata_e;
    logic            answer_ok_reg, answer_ok_next, ok_e;
    logic [15:0]     word;

    // A start marker restarts the parser before this byte is used
    always_comb
    begin
        ph_e    = first ? dmp_pkg::PH_HEADER : phase_reg;
        off_e   = first ? 4'd0 : offset_reg;
        label_e = first ? 8'd0 : label_left_reg;
        ans_e   = first ? 1'b0 : answers_reg;
        hold_e  = first ? 8'd0 : hold_reg;
        rdata_e = first ? 16'd0 : rdata_left_reg;
        ok_e    = first ? 1'b0 : answer_ok_reg;
        word    = {hold_e, data_byte};
    end

    // Next state
    always_comb
    begin
        phase_next      = ph_e;
        offset_next     = off_e;
        label_left_next = label_e;
        answers_next    = ans_e;
        hold_next       = hold_e;
        rdata_left_next = rdata_e;
        answer_ok_next  = ok_e;
        case (ph_e)
            dmp_pkg::PH_HEADER:
            begin
                if (off_e == dmp_pkg::ANCOUNT_HI_AT)
                    hold_next = data_byte;
                else if (off_e == dmp_pkg::ANCOUNT_LO_AT)
                    answers_next = (hold_e | data_byte) != 8'd0;
                if (off_e == dmp_pkg::HEADER_LAST_AT)
                begin
                    offset_next = 4'd0;
                    phase_next  = dmp_pkg::PH_LABEL_LEN;
                end
                else
                    offset_next = off_e + 4'd1;
            end
            dmp_pkg::PH_LABEL_LEN:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next  = dmp_pkg::PH_TAIL;
                    offset_next = 4'd0;
                end
                else
                begin
                    label_left_next = data_byte;
                    phase_next      = dmp_pkg::PH_LABEL_CHAR;
                end
            end
            dmp_pkg::PH_LABEL_CHAR:
            begin
                label_left_next = label_e - 8'd1;
                if (label_e == 8'd1)
                    phase_next = dmp_pkg::PH_LABEL_LEN;
            end
            dmp_pkg::PH_TAIL:
            begin
                offset_next = off_e + 4'd1;
                if (off_e == dmp_pkg::ATYPE_LO_AT)
                    answer_ok_next = ans_e && (word == dmp_pkg::AAAA_TYPE);
                else if (off_e == dmp_pkg::RDLEN_LO_AT)
                begin
                    rdata_left_next = word;
                    phase_next = (ok_e && word != 16'd0) ? dmp_pkg::PH_RDATA
                                                         : dmp_pkg::PH_DONE;
                end
                else if (off_e != dmp_pkg::QTYPE_LO_AT)
                    hold_next = data_byte;
            end
            dmp_pkg::PH_RDATA:
            begin
                rdata_left_next = rdata_e - 16'd1;
                if (rdata_e == 16'd1)
                    phase_next = dmp_pkg::PH_DONE;
            end
            default:
            begin
            end
        endcase
    end

    // Result for this byte
    always_comb
    begin
        res = '0;
        case (ph_e)
            dmp_pkg::PH_LABEL_LEN:
            begin
                if (data_byte == 8'd0)
                begin
                    res.valid = 1'b1;
                    res.kind  = dmp_pkg::KIND_NAME_END;
                end
            end
            dmp_pkg::PH_LABEL_CHAR:
            begin
                res.valid     = 1'b1;
                res.kind      = dmp_pkg::KIND_CHAR;
                res.value     = data_byte;
                res.label_end = (label_e == 8'd1);
            end
            dmp_pkg::PH_TAIL:
            begin
                if (off_e == dmp_pkg::QTYPE_LO_AT)
                begin
                    res.valid   = 1'b1;
                    res.kind    = dmp_pkg::KIND_QTYPE;
                    res.verdict = (word == dmp_pkg::AAAA_TYPE);
                end
                else if (off_e == dmp_pkg::ATYPE_LO_AT)
                begin
                    res.valid   = 1'b1;
                    res.kind    = dmp_pkg::KIND_ANSWER;
                    res.verdict = ans_e && (word == dmp_pkg::AAAA_TYPE);
                end
            end
            dmp_pkg::PH_RDATA:
            begin
                res.valid     = 1'b1;
                res.kind      = dmp_pkg::KIND_ADDR;
                res.value     = data_byte;
                res.last_byte = (rdata_e == 16'd1);
            end
            default:
            begin
            end
        endcase
    end

    // State registers, updated once per stepped byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dmp_pkg::PH_IDLE;
            offset_reg     <= 4'd0;
            label_left_reg <= 8'd0;
            answers_reg    <= 1'b0;
            hold_reg       <= 8'd0;
            rdata_left_reg <= 16'd0;
            answer_ok_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            offset_reg     <= offset_next;
            label_left_reg <= label_left_next;
            answers_reg    <= answers_next;
            hold_reg       <= hold_next;
            rdata_left_reg <= rdata_left_next;
            answer_ok_reg  <= answer_ok_next;
        end
    end

    // Address bytes only flow for a valid answer with bytes left
    `DMP_ASSERT_ALWAYS(a_rdata_needs_ok,
        phase_reg == dmp_pkg::PH_RDATA |-> answer_ok_reg && rdata_left_reg != 16'd0)
    // A label in progress always has characters left
    `DMP_ASSERT_ALWAYS(a_label_nonzero,
        phase_reg == dmp_pkg::PH_LABEL_CHAR |-> label_left_reg != 8'd0)
    // The final address byte closes the message
    `DMP_ASSERT(a_last_addr_done,
        step && !first && phase_reg == dmp_pkg::PH_RDATA && rdata_left_reg == 16'd1
        |=> phase_reg == dmp_pkg::PH_DONE)
    // Without a step the parser holds its place
    `DMP_ASSERT(a_hold_no_step,
        !step |=> $stable(phase_reg) && $stable(offset_reg) && $stable(rdata_left_reg))

endmodule

@@ sv/dmp_result_reg.sv @@
// ---------------------------------------------------------------------------
// DNS message parser result register
// Holds one result record until the downstream side takes it.
// ---------------------------------------------------------------------------
module dmp_result_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  dmp_pkg::res_t  res,
    input  logic           result_stall,
    output logic           result_valid,
    output logic [2:0]     kind,
    output logic [7:0]     value,
    output logic           label_end,
    output logic           verdict,
    output logic           last_byte
);

    logic          valid_reg, valid_next;
    dmp_pkg::res_t data_reg;

    // Occupancy: refilled on a load, emptied when taken
    always_comb
    begin
        if (load)
            valid_next = res.valid;
        else if (valid_reg && !result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, loaded only with a real result
    always_ff @(posedge clk)
    begin
        if (load && res.valid)
            data_reg <= res;
    end

    assign result_valid = valid_reg;
    assign kind         = data_reg.kind;
    assign value        = data_reg.value;
    assign label_end    = data_reg.label_end;
    assign verdict      = data_reg.verdict;
    assign last_byte    = data_reg.last_byte;

endmodule

@@ sv/dns_message_parser.sv @@
// Each byte passes through the input register and then the result register;
// its result is offered from the result register.
// Throughput: one byte per cycle; the input register passes a byte to the
// walker whenever the result register is empty or being taken.
// Reset clears the parser to idle and both registers to empty; bytes are
// ignored until one arrives with the start marker set.
// ---------------------------------------------------------------------------
// DNS message parser top level
// Walks a length-prefixed DNS response byte stream and reports the question
// name, type verdicts and AAAA address bytes.
// ---------------------------------------------------------------------------
module dns_message_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       first,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic       label_end,
    output logic       verdict,
    output logic       last_byte
);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_first_reg;
    logic          advance;
    logic          accept;
    dmp_pkg::res_t res;

    // Handshake between input register and result register
    assign advance    = in_valid_reg && (!result_valid || !result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= data_byte;
            in_first_reg <= first;
        end
    end

    dmp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .first     (in_first_reg),
        .res       (res)
    );

    dmp_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .kind         (kind),
        .value        (value),
        .label_end    (label_end),
        .verdict      (verdict),
        .last_byte    (last_byte)
    );

endmodule
